FILE: src/well_pkg.sv
// ----------------------------------------------------------------------------
// well_pkg: shared types and constants of the four-lane WELL512a generator
// Lane count, ring geometry, recurrence taps and the command codes used by
// the lane cores, the result stage and the top level.
// ----------------------------------------------------------------------------
package well_pkg;

    localparam int LANES       = 4;
    localparam int STATE_WORDS = 16;
    localparam int OUT_FIELDS  = 4;
    localparam int WORD_W      = 32;
    localparam int POS_W       = $clog2(STATE_WORDS);
    localparam int IDX_W       = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = OUT_FIELDS * WORD_W;

    // Recurrence taps, relative to the ring position.
    localparam int TAP_M1 = 13;
    localparam int TAP_M2 = 9;
    localparam int TAP_Q  = STATE_WORDS - 1;

    localparam logic [WORD_W-1:0] WELL_MIX = 32'hda44_2d24;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef enum logic {
        CMD_GENERATE = 1'b0,
        CMD_LOAD     = 1'b1
    } cmd_t;

    // Control that the top level hands to every lane in an accepted cycle.
    typedef struct packed {
        logic  gen;     // generate: run the recurrence and shift the ring
        logic  load;    // load: realign the ring to position zero
        logic  wr;      // this lane takes the seed word
        pos_t  entry;   // seed entry within the lane
        pos_t  pos;     // current ring position
        word_t value;   // seed word
    } lane_ctrl_t;

endpackage

FILE: src/well512a_random_four_lane.sv
// ----------------------------------------------------------------------------
// well512a_random_four_lane: four-lane WELL512a random number generator
// Four independent WELL512a lanes share one ring position. A load word seeds
// one state word of one lane; a generate word returns one new word per lane.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Ports                          | Contents
//  --------+-----+--------------------------------+---------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | command word: load/generate
//  m_      | out | m_tvalid m_tready m_tdata      | four 32-bit random words
//
// A word is accepted on every cycle where s_tvalid and s_tready are high, so
// one generate word per cycle is sustained while m_ drains. The recurrence
// is evaluated in the cycle of acceptance and its result is registered in a
// two-entry output buffer whose head drives m_; the buffer keeps s_tready
// high while one result waits. s_tready falls only when two results are held
// or while aresetn is low. Reset (aresetn low, sampled on aclk) sets the ring
// position to zero and empties the buffer; it does not clear the state words,
// so all 64 seed words must be loaded before the first generate.
module well512a_random_four_lane (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] seed_index, [37:6] seed_value, [39:38] zero
    input  logic [well_pkg::S_TDATA_W-1:0]    s_tdata,
    // [0] cmd: 0 generate, 1 load
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] lane0_value, [63:32] lane1_value, [95:64] lane2_value,
    // [127:96] lane3_value
    output logic [well_pkg::M_TDATA_W-1:0]    m_tdata
);
    import well_pkg::*;

    logic              accept;
    logic              is_gen;
    logic              is_load;
    logic [IDX_W-1:0]  seed_index;
    word_t             seed_value;
    pos_t              pos_reg;
    pos_t              pos_next;
    word_t             lane_word [LANES];

    assign accept     = s_tvalid && s_tready;
    assign is_gen     = accept && (cmd_t'(s_tuser) == CMD_GENERATE);
    assign is_load    = accept && (cmd_t'(s_tuser) == CMD_LOAD);
    assign seed_index = s_tdata[IDX_W-1:0];
    assign seed_value = s_tdata[IDX_W +: WORD_W];

    // The ring position steps down by one per generate and returns to zero on
    // every load, whichever lane the seed word targets.
    always_comb begin
        if (is_load) begin
            pos_next = '0;
        end else if (is_gen) begin
            pos_next = pos_reg - pos_t'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Lane l takes seed words whose index lies in [16*l, 16*l+15].
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        lane_ctrl_t ctrl;

        always_comb begin
            ctrl.gen   = is_gen;
            ctrl.load  = is_load;
            ctrl.wr    = (int'(seed_index[IDX_W-1:POS_W]) == l);
            ctrl.entry = seed_index[POS_W-1:0];
            ctrl.pos   = pos_reg;
            ctrl.value = seed_value;
        end

        well_lane u_lane (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .r1_word (lane_word[l])
        );
    end

    well_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_word (lane_word),
        .push      (is_gen),
        .in_ready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/well_lane.sv
// ----------------------------------------------------------------------------
// well_lane: one WELL512a generator lane
// Holds the 16 state words as a shifting ring, so that the recurrence always
// reads fixed taps; a load rotates the ring back to position zero.
// ----------------------------------------------------------------------------
module well_lane (
    input  logic               aclk,
    input  well_pkg::lane_ctrl_t ctrl,
    output well_pkg::word_t    r1_word
);
    import well_pkg::*;

    // ring_reg[k] holds state word (pos + k) mod STATE_WORDS.
    word_t ring_reg  [STATE_WORDS];
    word_t ring_next [STATE_WORDS];
    word_t aligned   [STATE_WORDS];

    word_t z1;
    word_t z2;
    word_t r0;

    always_comb begin
        z1 = ring_reg[0] ^ (ring_reg[0] << 16)
           ^ ring_reg[TAP_M1] ^ (ring_reg[TAP_M1] << 15);
        z2 = ring_reg[TAP_M2] ^ (ring_reg[TAP_M2] >> 11);
        r0 = z1 ^ z2;
        r1_word = ring_reg[TAP_Q] ^ (ring_reg[TAP_Q] << 2) ^ z1 ^ (z1 << 18)
                ^ (z2 << 28) ^ r0 ^ ((r0 << 5) & WELL_MIX);
    end

    // Word k of the state sits at ring slot (k - pos).
    always_comb begin
        for (int k = 0; k < STATE_WORDS; k++) begin
            aligned[k] = ring_reg[POS_W'(k) - ctrl.pos];
        end
    end

    always_comb begin
        for (int k = 0; k < STATE_WORDS; k++) begin
            if (ctrl.gen) begin
                // The new position is one lower: slot 0 gets r1, slot 1 r0.
                if (k == 0) begin
                    ring_next[k] = r1_word;
                end else if (k == 1) begin
                    ring_next[k] = r0;
                end else begin
                    ring_next[k] = ring_reg[k-1];
                end
            end else if (ctrl.load) begin
                if (ctrl.wr && (ctrl.entry == POS_W'(k))) begin
                    ring_next[k] = ctrl.value;
                end else begin
                    ring_next[k] = aligned[k];
                end
            end else begin
                ring_next[k] = ring_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STATE_WORDS; k++) begin
            ring_reg[k] <= ring_next[k];
        end
    end

endmodule

FILE: src/well_merge.sv
// ----------------------------------------------------------------------------
// well_merge: result stage
// Packs the lane words into one result word and holds it in a two-entry
// output buffer (head plus skid) so input acceptance is decoupled from stalls.
// ----------------------------------------------------------------------------
module well_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  well_pkg::word_t                   lane_word [well_pkg::LANES],
    input  logic                              push,
    output logic                              in_ready,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [well_pkg::M_TDATA_W-1:0]    m_tdata
);
    import well_pkg::*;

    logic [M_TDATA_W-1:0] result;
    logic [M_TDATA_W-1:0] head_reg;
    logic [M_TDATA_W-1:0] skid_reg;
    logic                 head_valid_reg;
    logic                 skid_valid_reg;
    logic                 pop;

    for (genvar o = 0; o < OUT_FIELDS; o++) begin : g_field
        if (o < LANES) begin : g_lane
            assign result[o*WORD_W +: WORD_W] = lane_word[o];
        end else begin : g_zero
            assign result[o*WORD_W +: WORD_W] = '0;
        end
    end

    assign pop      = head_valid_reg && m_tready;
    assign in_ready = aresetn && !skid_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !head_valid_reg) begin
            if (skid_valid_reg) begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                head_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !head_valid_reg) begin
            head_reg <= skid_valid_reg ? skid_reg : result;
        end else if (push) begin
            skid_reg <= result;
        end
    end

endmodule

FILE: src/well_chk.sv
// ----------------------------------------------------------------------------
// well_chk: port-level checks of the four-lane WELL512a generator
// Watches the stream ports and flags results without a generate word, lost
// backpressure and misbehavior around reset.
// ----------------------------------------------------------------------------
module well_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [well_pkg::M_TDATA_W-1:0]    m_tdata
);
    import well_pkg::*;

    // A result only appears right after a generate word was taken.
    a_result_from_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == CMD_GENERATE)))
        else $error("result appeared without a generate word");

    // Input is only held off while a result is waiting.
    a_ready_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind well512a_random_four_lane well_chk u_well_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
